// File: hdl/gro_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid package
// Shared sizes, command item type and helpers of the rectangle occupancy unit.
// ----------------------------------------------------------------------------
package gro_pkg;

	localparam int MAX_COLUMNS   = 64;
	localparam int MAX_ROWS      = 64;
	localparam int MAX_RECT_SIDE = 16;

	localparam int MAP_DEPTH = MAX_ROWS * MAX_COLUMNS;
	localparam int ADDR_W    = $clog2(MAP_DEPTH);
	localparam int RIDX_W    = $clog2(MAX_ROWS);
	localparam int CIDX_W    = $clog2(MAX_COLUMNS);
	localparam int REM_W     = CIDX_W;

	localparam int DIM_W    = 7;
	localparam int CENTER_W = 12;
	localparam int SIDE_W   = 5;
	localparam int CNT_W    = $clog2(MAX_RECT_SIDE);
	localparam int DIV_W    = $clog2(CENTER_W);

	// signed cell coordinates of the rectangle
	localparam int ROW_W = CENTER_W + 2;
	localparam int COL_W = DIM_W + 1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	localparam logic CFG_COLUMN_COUNT = 1'b0;
	localparam logic CFG_ROW_COUNT    = 1'b1;

	typedef struct packed {
		logic              op;
		logic              st;
		logic [SIDE_W-1:0] rh;
		logic [SIDE_W-1:0] rw;
		logic [ROW_W-1:0]  r0;
		logic [COL_W-1:0]  c0;
		logic              center_clip;
	} cmd_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
	                                               input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		if (v > SIDE_W'(MAX_RECT_SIDE)) begin
			r = SIDE_W'(MAX_RECT_SIDE);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// File: hdl/grid_rectangle_occupancy_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid rectangle occupancy unit
// Occupancy map of up to 64 x 64 cells with rectangle write and check items.
// ----------------------------------------------------------------------------
// After reset the map is cleared one cell a cycle, during which in_stall
// stays high; configuration writes are taken meanwhile. Each item then
// passes the front end, where a bit-serial divider turns the centre index
// into row and column, and then the back end, which visits one map cell per
// cycle through the single port of the map memory. The back end starts an
// item only once the previous result has been taken, and the front end
// divides the next item in the shadow of the current walk; in_stall stays
// high from the acceptance of an item until it has been queued.
// ----------------------------------------------------------------------------
module grid_rectangle_occupancy_unit import gro_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [DIM_W-1:0]    cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                opcode,
	input  logic [CENTER_W-1:0] center_index,
	input  logic [SIDE_W-1:0]   rect_rows,
	input  logic [SIDE_W-1:0]   rect_cols,
	input  logic                cell_state,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                placeable,
	output logic                clipped
);

	logic [DIM_W-1:0] column_count_q;
	logic [DIM_W-1:0] row_count_q;
	logic [DIM_W-1:0] cols;
	logic [DIM_W-1:0] rows;
	logic             map_ready;
	logic             q_push;
	logic             q_full;
	logic             q_pop;
	logic             q_valid;
	cmd_t             q_wdata;
	cmd_t             q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= DIM_W'(MAX_COLUMNS);
			row_count_q    <= DIM_W'(MAX_ROWS);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLUMN_COUNT: column_count_q <= cfg_wdata;
				CFG_ROW_COUNT:    row_count_q    <= cfg_wdata;
				default:          row_count_q    <= row_count_q;
			endcase
		end
	end

	assign cols = clamp_dim(column_count_q, DIM_W'(MAX_COLUMNS));
	assign rows = clamp_dim(row_count_q, DIM_W'(MAX_ROWS));

	gro_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.center_index (center_index),
		.rect_rows    (rect_rows),
		.rect_cols    (rect_cols),
		.cell_state   (cell_state),
		.cols         (cols),
		.rows         (rows),
		.map_ready    (map_ready),
		.q_push       (q_push),
		.q_wdata      (q_wdata),
		.q_full       (q_full)
	);

	gro_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	gro_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cols      (cols),
		.rows      (rows),
		.q_valid   (q_valid),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.map_ready (map_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.placeable (placeable),
		.clipped   (clipped)
	);

endmodule

// File: hdl/gro_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid front end
// Takes an item, splits the centre index into row and column with a
// bit-serial divider and queues the rectangle origin for the back end.
// ----------------------------------------------------------------------------
module gro_front import gro_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                opcode,
	input  logic [CENTER_W-1:0] center_index,
	input  logic [SIDE_W-1:0]   rect_rows,
	input  logic [SIDE_W-1:0]   rect_cols,
	input  logic                cell_state,
	input  logic [DIM_W-1:0]    cols,
	input  logic [DIM_W-1:0]    rows,
	input  logic                map_ready,
	output logic                q_push,
	output cmd_t                q_wdata,
	input  logic                q_full
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t             state_q;
	logic [DIV_W-1:0]    cnt_q;
	logic [CENTER_W-1:0] dvd_q;
	logic [REM_W-1:0]    rem_q;
	logic                op_q;
	logic                st_q;
	logic [SIDE_W-1:0]   rh_q;
	logic [SIDE_W-1:0]   rw_q;

	logic                accept;
	logic [DIM_W-1:0]    trial;
	logic [DIM_W-1:0]    diff;
	logic                ge;

	assign in_stall = (state_q != F_IDLE) || !map_ready;
	assign accept   = in_valid && !in_stall;

	// one quotient bit a cycle
	assign trial = {rem_q, dvd_q[CENTER_W-1]};
	assign ge    = trial >= cols;
	assign diff  = trial - cols;

	assign q_push = (state_q == F_PUSH) && !q_full;

	always_comb begin
		q_wdata.op          = op_q;
		q_wdata.st          = st_q;
		q_wdata.rh          = rh_q;
		q_wdata.rw          = rw_q;
		q_wdata.r0          = {{(ROW_W-CENTER_W){1'b0}}, dvd_q}
		                      - {{(ROW_W-SIDE_W){1'b0}}, rh_q >> 1};
		q_wdata.c0          = {{(COL_W-REM_W){1'b0}}, rem_q}
		                      - {{(COL_W-SIDE_W){1'b0}}, rw_q >> 1};
		q_wdata.center_clip = dvd_q >= {{(CENTER_W-DIM_W){1'b0}}, rows};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_DIV;
						cnt_q   <= '0;
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + DIV_W'(1);
					if (cnt_q == DIV_W'(CENTER_W - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dvd_q <= center_index;
			rem_q <= '0;
			op_q  <= opcode;
			st_q  <= cell_state;
			rh_q  <= clamp_side(rect_rows);
			rw_q  <= clamp_side(rect_cols);
		end else if (state_q == F_DIV) begin
			dvd_q <= {dvd_q[CENTER_W-2:0], ge};
			rem_q <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
		end
	end

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_PUSH |-> {1'b0, rem_q} < cols)
		else $error("remainder not below column count");

endmodule

// File: hdl/gro_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid command queue
// Short FIFO of rectangle commands between the front and back ends.
// ----------------------------------------------------------------------------
module gro_queue import gro_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t rdata
);

	cmd_t              ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign valid = cnt_q != '0;
	assign rdata = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= wdata;
		end
	end

endmodule

// File: hdl/gro_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occupancy grid back end
// Holds the map, walks each rectangle one cell a cycle and forms the result.
// ----------------------------------------------------------------------------
module gro_back import gro_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIM_W-1:0] cols,
	input  logic [DIM_W-1:0] rows,
	input  logic             q_valid,
	input  cmd_t             q_rdata,
	output logic             q_pop,
	output logic             map_ready,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             placeable,
	output logic             clipped
);

	typedef enum logic [2:0] {
		B_CLEAR = 3'b001,
		B_IDLE  = 3'b010,
		B_RUN   = 3'b100
	} bstate_t;

	localparam int AFULL_W = RIDX_W + DIM_W;

	bstate_t                 state_q;
	logic [ADDR_W-1:0]       clr_q;
	cmd_t                    cur_q;
	logic [CNT_W-1:0]        i_q;
	logic [CNT_W-1:0]        j_q;
	logic                    acc_ok_q;
	logic                    acc_clip_q;
	logic                    out_valid_q;
	logic                    placeable_q;
	logic                    clipped_q;

	logic                    v_s1;
	logic signed [ROW_W-1:0] r_s1;
	logic signed [COL_W-1:0] c_s1;
	logic                    last_s1;
	logic                    v_s2;
	logic                    inb_s2;
	logic                    last_s2;
	logic                    rd_s2;

	logic                    map_mem [MAP_DEPTH];

	logic                    rect_empty;
	logic                    i_last;
	logic                    j_last;
	logic                    inb_s1;
	logic [AFULL_W-1:0]      addr_full;
	logic [ADDR_W-1:0]       addr_s1;
	logic                    ok_nx;
	logic                    clip_nx;
	logic                    out_take;

	assign map_ready  = state_q != B_CLEAR;
	assign out_valid  = out_valid_q;
	assign placeable  = placeable_q;
	assign clipped    = clipped_q;
	assign out_take   = out_valid_q && !out_stall;

	assign q_pop      = (state_q == B_IDLE) && q_valid && !out_valid_q && !v_s1 && !v_s2;
	assign rect_empty = (q_rdata.rh == '0) || (q_rdata.rw == '0);
	assign i_last     = {1'b0, i_q} == cur_q.rh - SIDE_W'(1);
	assign j_last     = {1'b0, j_q} == cur_q.rw - SIDE_W'(1);

	assign inb_s1 = (r_s1 >= 0)
	             && (r_s1 < $signed({{(ROW_W-DIM_W){1'b0}}, rows}))
	             && (c_s1 >= 0)
	             && (c_s1 < $signed({{(COL_W-DIM_W){1'b0}}, cols}));
	assign addr_full = AFULL_W'(r_s1[RIDX_W-1:0]) * AFULL_W'(cols)
	                 + {{(AFULL_W-CIDX_W){1'b0}}, c_s1[CIDX_W-1:0]};
	assign addr_s1   = addr_full[ADDR_W-1:0];

	assign ok_nx   = acc_ok_q && !(v_s2 && inb_s2 && (cur_q.op == OP_CHECK)
	                               && (rd_s2 != cur_q.st));
	assign clip_nx = acc_clip_q || (v_s2 && !inb_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			acc_ok_q    <= 1'b1;
			acc_clip_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= 1'b0;
			v_s2 <= v_s1;
			if (out_take) begin
				out_valid_q <= 1'b0;
			end
			if (v_s2) begin
				acc_ok_q   <= ok_nx;
				acc_clip_q <= clip_nx;
				if (last_s2) begin
					out_valid_q <= 1'b1;
				end
			end
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(MAP_DEPTH - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (q_pop) begin
						i_q        <= '0;
						j_q        <= '0;
						acc_ok_q   <= 1'b1;
						acc_clip_q <= q_rdata.center_clip;
						if (rect_empty) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q <= B_RUN;
						end
					end
				end
				B_RUN: begin
					v_s1 <= 1'b1;
					if (j_last) begin
						j_q <= '0;
						i_q <= i_q + CNT_W'(1);
						if (i_last) begin
							state_q <= B_IDLE;
						end
					end else begin
						j_q <= j_q + CNT_W'(1);
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_rdata;
			if (rect_empty) begin
				placeable_q <= (q_rdata.op == OP_CHECK) && !q_rdata.center_clip;
				clipped_q   <= q_rdata.center_clip;
			end
		end
		if (state_q == B_RUN) begin
			r_s1    <= $signed(cur_q.r0) + $signed({{(ROW_W-CNT_W){1'b0}}, i_q});
			c_s1    <= $signed(cur_q.c0) + $signed({{(COL_W-CNT_W){1'b0}}, j_q});
			last_s1 <= i_last && j_last;
		end
		inb_s2  <= inb_s1;
		last_s2 <= last_s1;
		if (v_s2 && last_s2) begin
			placeable_q <= (cur_q.op == OP_CHECK) && ok_nx && !clip_nx;
			clipped_q   <= clip_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_CLEAR) begin
			map_mem[clr_q] <= 1'b0;
		end else if (v_s1 && inb_s1 && (cur_q.op == OP_WRITE)) begin
			map_mem[addr_s1] <= cur_q.st;
		end
		rd_s2 <= map_mem[addr_s1];
	end

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_CLEAR |-> !v_s1 && !v_s2 && !out_valid_q)
		else $error("cell traffic during map clear");

	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && last_s2 |=> out_valid_q)
		else $error("last cell did not produce a result");

	a_run_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_RUN |-> !out_valid_q)
		else $error("rectangle walk started over an untaken result");

endmodule

// File: tb/sv/grid_rectangle_occupancy_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid rectangle occupancy unit testbench
// Sends rectangle write and check items under several grid sizes, keeps its
// own copy of the occupancy map to work out each result, and compares every
// result in order, with random gaps on the sender and stalls on the receiver.
// ----------------------------------------------------------------------------
module grid_rectangle_occupancy_unit_tb;
	import gro_pkg::*;

	localparam logic CELL_EMPTY    = 1'b0;
	localparam logic CELL_OBSTACLE = 1'b1;
	localparam int   MAX_REPORTS   = 40;
	localparam int   PHASE_ITEMS   = 145;

	typedef struct packed {
		logic placeable;
		logic clipped;
	} verdict_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                cfg_we       = 1'b0;
	logic                cfg_index    = CFG_COLUMN_COUNT;
	logic [DIM_W-1:0]    cfg_wdata    = '0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic                opcode       = OP_WRITE;
	logic [CENTER_W-1:0] center_index = '0;
	logic [SIDE_W-1:0]   rect_rows    = '0;
	logic [SIDE_W-1:0]   rect_cols    = '0;
	logic                cell_state   = CELL_EMPTY;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic                placeable;
	logic                clipped;

	bit               grid_map [MAP_DEPTH];
	logic [DIM_W-1:0] grid_columns = 7'd64;
	logic [DIM_W-1:0] grid_rows    = 7'd64;
	verdict_t         verdicts_due [$];
	int               error_count;
	int               items_sent;
	bit               sender_gaps;
	bit               receiver_stalls;
	int               stall_left;

	grid_rectangle_occupancy_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.center_index (center_index),
		.rect_rows    (rect_rows),
		.rect_cols    (rect_cols),
		.cell_state   (cell_state),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.placeable    (placeable),
		.clipped      (clipped)
	);

	always #2 clk = ~clk;

	function automatic int clamp_grid(input logic [DIM_W-1:0] v, input int limit);
		int n;
		n = int'(v);
		if (n < 1) begin
			n = 1;
		end else if (n > limit) begin
			n = limit;
		end
		return n;
	endfunction

	// applies one item to the local map and returns the result it should give
	function automatic verdict_t occupancy_step(input logic op,
	                                            input logic [CENTER_W-1:0] centre,
	                                            input logic [SIDE_W-1:0] rows_in,
	                                            input logic [SIDE_W-1:0] cols_in,
	                                            input logic st);
		int       ncols, nrows, height, width, crow, ccol, top, left, r, c;
		bit       off_grid, all_match;
		verdict_t v;
		ncols     = clamp_grid(grid_columns, MAX_COLUMNS);
		nrows     = clamp_grid(grid_rows, MAX_ROWS);
		height    = (int'(rows_in) > MAX_RECT_SIDE) ? MAX_RECT_SIDE : int'(rows_in);
		width     = (int'(cols_in) > MAX_RECT_SIDE) ? MAX_RECT_SIDE : int'(cols_in);
		crow      = int'(centre) / ncols;
		ccol      = int'(centre) % ncols;
		off_grid  = (crow >= nrows);
		all_match = 1'b1;
		top       = crow - height / 2;
		left      = ccol - width / 2;
		for (int i = 0; i < height; i++) begin
			for (int j = 0; j < width; j++) begin
				r = top + i;
				c = left + j;
				if (r < 0 || r >= nrows || c < 0 || c >= ncols) begin
					off_grid = 1'b1;
				end else if (op == OP_WRITE) begin
					grid_map[r * ncols + c] = st;
				end else if (grid_map[r * ncols + c] != st) begin
					all_match = 1'b0;
				end
			end
		end
		v.placeable = (op == OP_CHECK) && all_match && !off_grid;
		v.clipped   = off_grid;
		return v;
	endfunction

	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_side();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return 0;
		if (r < 72) return $urandom_range(1, 5);
		if (r < 93) return $urandom_range(6, 16);
		return $urandom_range(17, 31);
	endfunction

	task automatic log_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("ERROR at %0t ns: %s", $time, msg);
		end
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(input logic op, input logic [CENTER_W-1:0] centre,
	                         input logic [SIDE_W-1:0] h, input logic [SIDE_W-1:0] w,
	                         input logic st);
		int gap;
		gap = sender_gaps ? idle_length() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode       <= op;
		center_index <= centre;
		rect_rows    <= h;
		rect_cols    <= w;
		cell_state   <= st;
		in_valid     <= 1'b1;
		do @(posedge clk); while (in_stall);
		verdicts_due.push_back(occupancy_step(op, centre, h, w, st));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [DIM_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		if (idx == CFG_COLUMN_COUNT) begin
			grid_columns = value;
		end else begin
			grid_rows = value;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_grid(input logic [DIM_W-1:0] ncols, input logic [DIM_W-1:0] nrows);
		drain_results();
		write_register(CFG_COLUMN_COUNT, ncols);
		write_register(CFG_ROW_COUNT, nrows);
	endtask

	task automatic test_directed_map();
		set_grid(7'd64, 7'd64);
		send_item(OP_CHECK, 12'd0, 5'd1, 5'd1, CELL_EMPTY);
		send_item(OP_WRITE, 12'd2080, 5'd16, 5'd16, CELL_OBSTACLE);
		send_item(OP_CHECK, 12'd2080, 5'd16, 5'd16, CELL_OBSTACLE);
		send_item(OP_CHECK, 12'd2080, 5'd3, 5'd3, CELL_EMPTY);
		// oversized sides saturate to the full rectangle
		send_item(OP_CHECK, 12'd2080, 5'd31, 5'd31, CELL_OBSTACLE);
		send_item(OP_WRITE, 12'd0, 5'd4, 5'd4, CELL_OBSTACLE);
		send_item(OP_CHECK, 12'd0, 5'd0, 5'd5, CELL_OBSTACLE);
		send_item(OP_WRITE, 12'd4095, 5'd16, 5'd16, CELL_EMPTY);
		send_item(OP_CHECK, 12'd4095, 5'd1, 5'd1, CELL_EMPTY);
		send_item(OP_WRITE, 12'd2080, 5'd8, 5'd8, CELL_EMPTY);
		send_item(OP_CHECK, 12'd2080, 5'd8, 5'd8, CELL_EMPTY);
		send_item(OP_WRITE, 12'd100, 5'd1, 5'd1, CELL_OBSTACLE);
		send_item(OP_CHECK, 12'd100, 5'd1, 5'd1, CELL_OBSTACLE);
	endtask

	task automatic test_register_extremes();
		// zero counts act as a single cell grid
		set_grid(7'd0, 7'd0);
		send_item(OP_CHECK, 12'd0, 5'd1, 5'd1, CELL_OBSTACLE);
		send_item(OP_WRITE, 12'd7, 5'd2, 5'd2, CELL_OBSTACLE);
		send_item(OP_CHECK, 12'd0, 5'd0, 5'd0, CELL_EMPTY);
		set_grid(7'd127, 7'd1);
		send_item(OP_CHECK, 12'd63, 5'd1, 5'd1, CELL_EMPTY);
		send_item(OP_CHECK, 12'd64, 5'd1, 5'd1, CELL_EMPTY);
		send_item(OP_WRITE, 12'd10, 5'd3, 5'd16, CELL_OBSTACLE);
		set_grid(7'd1, 7'd127);
		send_item(OP_CHECK, 12'd63, 5'd16, 5'd1, CELL_EMPTY);
		send_item(OP_WRITE, 12'd64, 5'd1, 5'd1, CELL_OBSTACLE);
		set_grid(7'd7, 7'd5);
		send_item(OP_WRITE, 12'd17, 5'd5, 5'd7, CELL_OBSTACLE);
		send_item(OP_CHECK, 12'd17, 5'd5, 5'd7, CELL_OBSTACLE);
	endtask

	task automatic random_burst();
		int           cells;
		logic [CENTER_W-1:0] centre;
		logic [SIDE_W-1:0]   h, w;
		logic                st;
		cells = clamp_grid(grid_columns, MAX_COLUMNS) * clamp_grid(grid_rows, MAX_ROWS);
		if ($urandom_range(0, 99) < 75) begin
			// place or remove, then confirm it
			centre = CENTER_W'($urandom_range(0, cells - 1));
			h      = SIDE_W'(pick_side());
			w      = SIDE_W'(pick_side());
			st     = 1'($urandom_range(0, 1));
			send_item(OP_WRITE, centre, h, w, st);
			send_item(OP_CHECK, centre, h, w, st);
			if ($urandom_range(0, 2) == 0) begin
				send_item(OP_CHECK, centre, SIDE_W'(pick_side()), SIDE_W'(pick_side()), ~st);
			end
		end else begin
			send_item(1'($urandom_range(0, 1)), CENTER_W'($urandom_range(0, 4095)),
			          SIDE_W'($urandom_range(0, 31)), SIDE_W'($urandom_range(0, 31)),
			          1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_random_traffic();
		int  target;
		bit  paused;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_grid(7'd64, 7'd64);
				1: set_grid(DIM_W'($urandom_range(1, 64)), DIM_W'($urandom_range(1, 64)));
				2: set_grid(DIM_W'($urandom_range(0, 127)), DIM_W'($urandom_range(0, 127)));
				3: set_grid(DIM_W'($urandom_range(1, 8)), DIM_W'($urandom_range(1, 8)));
				default: set_grid(DIM_W'($urandom_range(1, 64)), DIM_W'($urandom_range(1, 64)));
			endcase
			sender_gaps     = (phase != 0);
			receiver_stalls = (phase != 0) && (phase != 4);
			target = items_sent + PHASE_ITEMS;
			paused = 1'b0;
			while (items_sent < target) begin
				random_burst();
				if (!paused && items_sent >= target - PHASE_ITEMS / 2) begin
					drain_results();
					paused = 1'b1;
				end
			end
		end
		sender_gaps     = 1'b1;
		receiver_stalls = 1'b1;
	endtask

	always @(negedge clk) begin
		if (!receiver_stalls) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			stall_left = idle_length();
			out_stall <= (stall_left > 0);
			if (stall_left > 0) stall_left--;
		end
	end

	always @(posedge clk) begin : result_check
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (verdicts_due.size() == 0) begin
				log_mismatch("result with no item pending");
			end else begin
				want = verdicts_due.pop_front();
				if (placeable !== want.placeable) begin
					log_mismatch($sformatf("placeable %b, want %b", placeable, want.placeable));
				end
				if (clipped !== want.clipped) begin
					log_mismatch($sformatf("clipped %b, want %b", clipped, want.clipped));
				end
			end
		end
	end

	initial begin
		int waited;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_map();
		test_register_extremes();
		test_random_traffic();
		in_valid <= 1'b0;
		waited = 0;
		while (verdicts_due.size() != 0 && waited < 100000) begin
			@(negedge clk);
			waited++;
		end
		repeat (300) @(negedge clk);
		while (verdicts_due.size() != 0) begin
			void'(verdicts_due.pop_front());
			log_mismatch("expected result never arrived");
		end
		if (error_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#6_000_000;
		$display("timeout with %0d results outstanding", verdicts_due.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
